// ===== sv/ecd_pkg.sv =====
package ecd_pkg;

	localparam int unsigned DAY_SECS = 86400;
	localparam logic [63:0] MARCH_SHIFT_SECS = 64'd719468 * 64'(DAY_SECS);

	localparam int unsigned ERA_DIV_W = 27;
	localparam logic [63:0] ERA_DIV = 64'd146097 * 64'd675;

	localparam logic [9:0] DAY_UNIT = 10'd675;
	localparam int unsigned SH_675 = 37;
	localparam logic [27:0] M_675 = 28'(((64'd1 << SH_675) + 64'd674) / 64'd675);

	localparam logic [17:0] CENT_DAYS = 18'd36524;
	localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
	localparam int unsigned SH_1460 = 29;
	localparam logic [18:0] M_1460 = 19'(((64'd1 << SH_1460) + 64'd1459) / 64'd1460);

	localparam logic [8:0] YEAR_DAYS = 9'd365;
	localparam int unsigned SH_365 = 27;
	localparam logic [18:0] M_365 = 19'(((64'd1 << SH_365) + 64'd364) / 64'd365);

	localparam int unsigned SH_153 = 19;
	localparam logic [11:0] M_153 = 12'(((64'd1 << SH_153) + 64'd152) / 64'd153);

	localparam logic [11:0] HOUR_SECS = 12'd3600;
	localparam int unsigned SH_3600 = 29;
	localparam logic [17:0] M_3600 = 18'(((64'd1 << SH_3600) + 64'd3599) / 64'd3600);

	localparam logic [5:0] MIN_SECS = 6'd60;
	localparam int unsigned SH_60 = 18;
	localparam logic [12:0] M_60 = 13'(((64'd1 << SH_60) + 64'd59) / 64'd60);

	typedef struct packed {
		logic vld;
		logic [23:0] era;
		logic [ERA_DIV_W-1:0] rem;
		logic [6:0] low7;
	} ecd_era_t;

	typedef struct packed {
		logic vld;
		logic [23:0] era;
		logic [17:0] doe;
		logic [16:0] sod;
	} ecd_day_t;

	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0: r = 9'd0;
			4'd1: r = 9'd31;
			4'd2: r = 9'd61;
			4'd3: r = 9'd92;
			4'd4: r = 9'd122;
			4'd5: r = 9'd153;
			4'd6: r = 9'd184;
			4'd7: r = 9'd214;
			4'd8: r = 9'd245;
			4'd9: r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/ecd_front.sv =====
module ecd_front import ecd_pkg::*; #(
	parameter int EPOCH_BITS = 48,
	parameter int SUM_W = 49,
	parameter int DVD_W = 43,
	parameter logic [63:0] BIAS = 64'd0
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [EPOCH_BITS-1:0] epoch_seconds,
	input logic signed [17:0] offset_seconds,
	output logic vld,
	output logic [DVD_W-1:0] dvd,
	output logic [6:0] low7
);

	logic vld_s1;
	logic vld_s2;
	logic signed [SUM_W-1:0] sum_s1;
	logic [DVD_W-1:0] dvd_s2;
	logic [6:0] low7_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1 <= SUM_W'(epoch_seconds) + SUM_W'(offset_seconds)
			+ $signed(SUM_W'(MARCH_SHIFT_SECS));
		dvd_s2 <= DVD_W'(sum_s1 >>> 7) + DVD_W'(BIAS);
		low7_s2 <= sum_s1[6:0];
	end

	assign vld = vld_s2;
	assign dvd = dvd_s2;
	assign low7 = low7_s2;

endmodule

// ===== sv/ecd_era_div.sv =====
module ecd_era_div import ecd_pkg::*; #(
	parameter int DVD_W = 43,
	parameter logic [23:0] ERA_K_LO = 24'd0
) (
	input logic clk,
	input logic arst_n,
	input logic vld,
	input logic [DVD_W-1:0] dvd,
	input logic [6:0] low7,
	output ecd_era_t quot
);

	localparam int TW = DVD_W - ERA_DIV_W;
	localparam int QW = TW + 1;
	localparam int PW = 2 * TW + 1;
	localparam int RW = ERA_DIV_W + 2;
	localparam logic [QW-1:0] RECIP = QW'((64'd1 << (TW + ERA_DIV_W)) / ERA_DIV);
	localparam logic [RW-1:0] DIV_1 = RW'(ERA_DIV);
	localparam logic [RW-1:0] DIV_2 = RW'(ERA_DIV * 64'd2);
	localparam logic [RW-1:0] DIV_3 = RW'(ERA_DIV * 64'd3);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PW-1:0] prod_s1;
	logic [RW-1:0] lo_s1, lo_s2;
	logic [6:0] low7_s1, low7_s2, low7_s3, low7_s4;
	logic [QW-1:0] q_s2, q_s3, q_s4;
	logic [RW-1:0] m_s2;
	logic [RW-1:0] r_s3;
	logic [ERA_DIV_W-1:0] rem_s4;
	logic [QW-1:0] q_est;
	logic [1:0] fix;
	logic [RW-1:0] left;

	// The estimate from the top bits is low by at most three eras.
	assign q_est = prod_s1[TW +: QW];

	always_comb begin
		if (r_s3 >= DIV_3) begin
			fix = 2'd3;
			left = r_s3 - DIV_3;
		end else if (r_s3 >= DIV_2) begin
			fix = 2'd2;
			left = r_s3 - DIV_2;
		end else if (r_s3 >= DIV_1) begin
			fix = 2'd1;
			left = r_s3 - DIV_1;
		end else begin
			fix = 2'd0;
			left = r_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(dvd[DVD_W-1 -: TW]) * PW'(RECIP);
		lo_s1 <= dvd[RW-1:0];
		low7_s1 <= low7;

		q_s2 <= q_est;
		m_s2 <= RW'(q_est) * DIV_1;
		lo_s2 <= lo_s1;
		low7_s2 <= low7_s1;

		r_s3 <= lo_s2 - m_s2;
		q_s3 <= q_s2;
		low7_s3 <= low7_s2;

		q_s4 <= q_s3 + QW'(fix);
		rem_s4 <= left[ERA_DIV_W-1:0];
		low7_s4 <= low7_s3;
	end

	assign quot.vld = vld_s4;
	assign quot.era = 24'(64'(q_s4)) - ERA_K_LO;
	assign quot.rem = rem_s4;
	assign quot.low7 = low7_s4;

endmodule

// ===== sv/ecd_split.sv =====
module ecd_split import ecd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input ecd_era_t quot,
	output ecd_day_t days
);

	logic vld_s1;
	logic vld_s2;
	logic [54:0] prod_s1;
	logic [ERA_DIV_W-1:0] rem_s1;
	logic [6:0] low7_s1;
	logic [23:0] era_s1;
	logic [23:0] era_s2;
	logic [17:0] doe_s2;
	logic [16:0] sod_s2;
	logic [17:0] doe;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= quot.vld;
			vld_s2 <= vld_s1;
		end
	end

	assign doe = prod_s1[SH_675 +: 18];

	always_ff @(posedge clk) begin
		prod_s1 <= 55'(quot.rem) * 55'(M_675);
		rem_s1 <= quot.rem;
		low7_s1 <= quot.low7;
		era_s1 <= quot.era;
		doe_s2 <= doe;
		sod_s2 <= {10'(rem_s1 - 27'(doe) * 27'(DAY_UNIT)), low7_s1};
		era_s2 <= era_s1;
	end

	assign days.vld = vld_s2;
	assign days.era = era_s2;
	assign days.doe = doe_s2;
	assign days.sod = sod_s2;

endmodule

// ===== sv/ecd_date.sv =====
module ecd_date import ecd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input ecd_day_t days,
	output logic done,
	output logic [23:0] year,
	output logic [3:0] month,
	output logic [4:0] day
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [17:0] doe_s1, doe_s2, doe_s3;
	logic [23:0] era_s1;
	logic [36:0] p1460_s1;
	logic [2:0] c36_s1;
	logic c146_s1;
	logic [17:0] num_s2;
	logic [23:0] era400_s2, era400_s3, era400_s4, era400_s5;
	logic [36:0] p365_s3;
	logic [8:0] doy_s4, doy_s5;
	logic [8:0] yoe_s4, yoe_s5;
	logic [22:0] p153_s5;
	logic [23:0] year_s6;
	logic [3:0] month_s6;
	logic [4:0] day_s6;

	logic [8:0] yoe;
	logic [1:0] c100;
	logic [17:0] base;
	logic [10:0] x153;
	logic [3:0] mp;
	logic [3:0] mon;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= days.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_comb begin
		yoe = p365_s3[SH_365 +: 9];
		c100 = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
		base = 18'(yoe) * 18'(YEAR_DAYS) + 18'(yoe[8:2]) - 18'(c100);
		x153 = 11'(doy_s4) * 11'd5 + 11'd2;
		mp = p153_s5[SH_153 +: 4];
		mon = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
	end

	always_ff @(posedge clk) begin
		doe_s1 <= days.doe;
		era_s1 <= days.era;
		p1460_s1 <= 37'(days.doe) * 37'(M_1460);
		c36_s1 <= 3'(days.doe >= CENT_DAYS) + 3'(days.doe >= CENT_DAYS * 18'd2)
			+ 3'(days.doe >= CENT_DAYS * 18'd3) + 3'(days.doe >= ERA_LAST_DAY);
		c146_s1 <= days.doe == ERA_LAST_DAY;

		num_s2 <= doe_s1 - 18'(p1460_s1[SH_1460 +: 7]) + 18'(c36_s1) - 18'(c146_s1);
		era400_s2 <= era_s1 * 24'd400;
		doe_s2 <= doe_s1;

		p365_s3 <= 37'(num_s2) * 37'(M_365);
		era400_s3 <= era400_s2;
		doe_s3 <= doe_s2;

		doy_s4 <= 9'(doe_s3 - base);
		yoe_s4 <= yoe;
		era400_s4 <= era400_s3;

		p153_s5 <= 23'(x153) * 23'(M_153);
		doy_s5 <= doy_s4;
		yoe_s5 <= yoe_s4;
		era400_s5 <= era400_s4;

		year_s6 <= era400_s5 + 24'(yoe_s5) + 24'(mon <= 4'd2);
		month_s6 <= mon;
		day_s6 <= 5'(doy_s5 - month_start(mp) + 9'd1);
	end

	assign done = vld_s6;
	assign year = year_s6;
	assign month = month_s6;
	assign day = day_s6;

endmodule

// ===== sv/ecd_clock.sv =====
module ecd_clock import ecd_pkg::*; (
	input logic clk,
	input logic [16:0] sod,
	output logic [4:0] hour,
	output logic [5:0] minute,
	output logic [5:0] second
);

	logic [34:0] ph_s1;
	logic [16:0] sod_s1;
	logic [4:0] hour_s2, hour_s3, hour_s4, hour_s5, hour_s6;
	logic [11:0] soh_s2, soh_s3;
	logic [24:0] pm_s3;
	logic [5:0] minute_s4, minute_s5, minute_s6;
	logic [5:0] second_s4, second_s5, second_s6;
	logic [4:0] hr;
	logic [5:0] mn;

	assign hr = ph_s1[SH_3600 +: 5];
	assign mn = pm_s3[SH_60 +: 6];

	always_ff @(posedge clk) begin
		ph_s1 <= 35'(sod) * 35'(M_3600);
		sod_s1 <= sod;

		hour_s2 <= hr;
		soh_s2 <= 12'(sod_s1 - 17'(hr) * 17'(HOUR_SECS));

		pm_s3 <= 25'(soh_s2) * 25'(M_60);
		hour_s3 <= hour_s2;
		soh_s3 <= soh_s2;

		hour_s4 <= hour_s3;
		minute_s4 <= mn;
		second_s4 <= 6'(soh_s3 - 12'(mn) * 12'(MIN_SECS));

		hour_s5 <= hour_s4;
		minute_s5 <= minute_s4;
		second_s5 <= second_s4;

		hour_s6 <= hour_s5;
		minute_s6 <= minute_s5;
		second_s6 <= second_s5;
	end

	assign hour = hour_s6;
	assign minute = minute_s6;
	assign second = second_s6;

endmodule

// ===== sv/epoch_to_civil_datetime_top.sv =====
// Channel   Handshake          Words
// input     start, busy        epoch_seconds, offset_seconds
// result    done               year, month, day, hour, minute, second
//
// One word is taken in every cycle; busy is never raised.
// The pipeline depth is the same at any EPOCH_BITS: two stages form the sum, four
// divide by the era length through a reciprocal multiplication, two split the day
// and six give the date.
// Results leave in the order the words came in.
// Reset clears only the valid bits of the pipeline; the receiver cannot stall it.
module epoch_to_civil_datetime_top import ecd_pkg::*; #(
	parameter int EPOCH_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [EPOCH_BITS-1:0] epoch_seconds,
	input logic signed [17:0] offset_seconds,
	output logic done,
	output logic signed [23:0] year,
	output logic [3:0] month,
	output logic [4:0] day,
	output logic [4:0] hour,
	output logic [5:0] minute,
	output logic [5:0] second
);

	localparam int SUM_W = ((EPOCH_BITS > 38) ? EPOCH_BITS : 38) + 1;
	localparam int DVD_W = SUM_W - 6;
	localparam logic [63:0] ERA_K = ((64'd1 << (DVD_W - 2)) + ERA_DIV - 64'd1) / ERA_DIV;
	localparam logic [63:0] ERA_BIAS = ERA_K * ERA_DIV;

	logic front_vld;
	logic [DVD_W-1:0] front_dvd;
	logic [6:0] front_low7;
	ecd_era_t quot;
	ecd_day_t days;
	logic [23:0] year_u;

	assign busy = 1'b0;

	ecd_front #(
		.EPOCH_BITS(EPOCH_BITS),
		.SUM_W(SUM_W),
		.DVD_W(DVD_W),
		.BIAS(ERA_BIAS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.epoch_seconds(epoch_seconds),
		.offset_seconds(offset_seconds),
		.vld(front_vld),
		.dvd(front_dvd),
		.low7(front_low7)
	);

	ecd_era_div #(
		.DVD_W(DVD_W),
		.ERA_K_LO(ERA_K[23:0])
	) u_era_div (
		.clk(clk),
		.arst_n(arst_n),
		.vld(front_vld),
		.dvd(front_dvd),
		.low7(front_low7),
		.quot(quot)
	);

	ecd_split u_split (
		.clk(clk),
		.arst_n(arst_n),
		.quot(quot),
		.days(days)
	);

	ecd_date u_date (
		.clk(clk),
		.arst_n(arst_n),
		.days(days),
		.done(done),
		.year(year_u),
		.month(month),
		.day(day)
	);

	ecd_clock u_clock (
		.clk(clk),
		.sod(days.sod),
		.hour(hour),
		.minute(minute),
		.second(second)
	);

	assign year = $signed(year_u);

endmodule

// ===== bench/civil_datetime_checker.sv =====
module civil_datetime_checker #(
	parameter int EPOCH_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic signed [EPOCH_BITS-1:0] epoch_seconds,
	input logic signed [17:0] offset_seconds,
	input logic done,
	input logic signed [23:0] year,
	input logic [3:0] month,
	input logic [4:0] day,
	input logic [4:0] hour,
	input logic [5:0] minute,
	input logic [5:0] second,
	output int pending,
	output int fails
);

	localparam longint SECS_PER_DAY = 86400;
	localparam longint SECS_PER_HOUR = 3600;
	localparam longint SECS_PER_MIN = 60;
	localparam longint DAYS_PER_ERA = 146097;
	localparam longint MARCH_SHIFT = 719468;

	typedef struct packed {
		logic [23:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} civil_t;

	civil_t expected_dates[$];

	function automatic void split_days(input longint secs, output longint days,
			output longint rest);
		days = secs / SECS_PER_DAY;
		rest = secs % SECS_PER_DAY;
		if (rest < 0) begin
			rest += SECS_PER_DAY;
			days -= 1;
		end
	endfunction

	function automatic civil_t civil_from_epoch(input logic signed [EPOCH_BITS-1:0] ep,
			input logic signed [17:0] off);
		longint ep_days, ep_rest, off_days, off_rest, days, sod;
		longint z, era, doe, yoe, doy, mp, mon, yr;
		civil_t c;
		split_days(longint'(ep), ep_days, ep_rest);
		split_days(longint'(off), off_days, off_rest);
		days = ep_days + off_days;
		sod = ep_rest + off_rest;
		if (sod >= SECS_PER_DAY) begin
			sod -= SECS_PER_DAY;
			days += 1;
		end
		// The civil year is counted from March so that the leap day falls last.
		z = days + MARCH_SHIFT;
		era = (z >= 0 ? z : z - (DAYS_PER_ERA - 1)) / DAYS_PER_ERA;
		doe = z - era * DAYS_PER_ERA;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		mon = (mp < 10) ? mp + 3 : mp - 9;
		yr = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
		c.year = yr[23:0];
		c.month = mon[3:0];
		c.day = 5'(doy - (153 * mp + 2) / 5 + 1);
		c.hour = 5'(sod / SECS_PER_HOUR);
		c.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
		c.second = 6'(sod % SECS_PER_MIN);
		return c;
	endfunction

	initial begin
		pending = 0;
		fails = 0;
	end

	always @(posedge clk) begin
		civil_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_dates.size() == 0) begin
					$error("result with no word waiting: year %0d", year);
					fails++;
				end else begin
					want = expected_dates.pop_front();
					if (year !== want.year) begin
						$error("year: expected %0d, got %0d", $signed(want.year), year);
						fails++;
					end
					if (month !== want.month) begin
						$error("month: expected %0d, got %0d", want.month, month);
						fails++;
					end
					if (day !== want.day) begin
						$error("day: expected %0d, got %0d", want.day, day);
						fails++;
					end
					if (hour !== want.hour) begin
						$error("hour: expected %0d, got %0d", want.hour, hour);
						fails++;
					end
					if (minute !== want.minute) begin
						$error("minute: expected %0d, got %0d", want.minute, minute);
						fails++;
					end
					if (second !== want.second) begin
						$error("second: expected %0d, got %0d", want.second, second);
						fails++;
					end
				end
			end
			if (start && !busy) begin
				expected_dates.push_back(civil_from_epoch(epoch_seconds, offset_seconds));
			end
		end
		pending <= expected_dates.size();
	end

endmodule

// ===== bench/epoch_to_civil_datetime_top_test.sv =====
module epoch_to_civil_datetime_top_test;

	localparam int EPOCH_BITS = 48;
	localparam longint EPOCH_MAX = (longint'(1) << (EPOCH_BITS - 1)) - 1;
	localparam longint EPOCH_MIN = -EPOCH_MAX - 1;
	localparam longint OFFSET_MAX = 131071;
	localparam longint OFFSET_MIN = -131072;
	localparam longint DAY_SECS = 86400;
	localparam longint ERA_DAYS = 146097;
	localparam longint MARCH_SHIFT = 719468;
	localparam int RANDOM_WORDS = 1950;
	localparam int DRAIN_CYCLES = 64;
	localparam int STALL_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [EPOCH_BITS-1:0] epoch_seconds = '0;
	logic signed [17:0] offset_seconds = '0;
	logic done;
	logic signed [23:0] year;
	logic [3:0] month;
	logic [4:0] day;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [5:0] second;
	int pending;
	int fails;
	int stall_cycles = 0;
	int burst_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	epoch_to_civil_datetime_top #(
		.EPOCH_BITS(EPOCH_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.epoch_seconds(epoch_seconds),
		.offset_seconds(offset_seconds),
		.done(done),
		.year(year),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second)
	);

	civil_datetime_checker #(
		.EPOCH_BITS(EPOCH_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.epoch_seconds(epoch_seconds),
		.offset_seconds(offset_seconds),
		.done(done),
		.year(year),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second),
		.pending(pending),
		.fails(fails)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

	function automatic longint rand_signed(input int bits);
		return $signed({$urandom, $urandom}) >>> (64 - bits);
	endfunction

	task automatic send_word(input longint secs, input longint offset);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			if ($urandom_range(0, 15) == 0) begin
				burst_left = $urandom_range(20, 60);
			end
			gap = $urandom_range(0, 18);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		epoch_seconds <= secs[EPOCH_BITS-1:0];
		offset_seconds <= offset[17:0];
		do @(posedge clk); while (busy);
	endtask

	task automatic send_day(input longint days, input longint sod, input longint offset);
		send_word(days * DAY_SECS + sod, offset);
	endtask

	initial begin
		longint doe_marks[18] = '{0, 1, 58, 59, 60, 305, 306, 364, 365, 1459, 1460, 1461,
			36523, 36524, 36525, 146094, 146095, 146096};
		longint era, doe;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(0, 0);
		send_word(-1, 0);
		send_word(EPOCH_MAX, 0);
		send_word(EPOCH_MIN, 0);
		send_word(EPOCH_MAX, OFFSET_MAX);
		send_word(EPOCH_MIN, OFFSET_MIN);
		send_word(EPOCH_MAX, OFFSET_MIN);
		send_word(EPOCH_MIN, OFFSET_MAX);
		send_word(1, 86399);
		send_word(0, -86399);
		send_word(86399, 1);
		send_word(-86400, -1);
		send_word(1735689599, 3600);
		send_day(11016, 43200, 0);
		send_day(-25508, 0, -1);
		send_day(-719468, 0, 0);
		send_day(-719469, 86399, 0);
		send_day(-719528, 0, 0);
		send_day(-719529, 45296, 0);
		send_day(146096 - MARCH_SHIFT, 86399, 1);
		send_day(-MARCH_SHIFT - 1, 0, 0);

		repeat (RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				0, 1: send_word(rand_signed(EPOCH_BITS), rand_signed(18));
				2, 3, 4: send_word(rand_signed(35), int'($urandom_range(0, 192)) * 900 - 86400);
				5, 6: send_day(rand_signed(31), int'($urandom_range(0, 4)) - 2,
					int'($urandom_range(0, 172798)) - 86399);
				7: begin
					era = int'($urandom_range(0, 22000)) - 11000;
					doe = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 146096))
						: doe_marks[$urandom_range(0, 17)];
					send_day(era * ERA_DAYS + doe - MARCH_SHIFT,
						($urandom_range(0, 1) == 0) ? longint'($urandom_range(0, 86399))
							: longint'($urandom_range(0, 1)) * 86399,
						int'($urandom_range(0, 172798)) - 86399);
				end
				default: send_word(rand_signed(21), rand_signed(18));
			endcase
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
